// File: hw/rtl/ttt_pkg.sv
// ----------------------------------------------------------------------------
// ttt_pkg
// Shared types and codes for the tick timer table: request and result
// payloads, command and result codes, and controller-to-datapath commands.
// ----------------------------------------------------------------------------
package ttt_pkg;

  // Request codes
  localparam logic [1:0] FUNC_TICK   = 2'd0;
  localparam logic [1:0] FUNC_ADD    = 2'd1;
  localparam logic [1:0] FUNC_REMOVE = 2'd2;
  localparam logic [1:0] FUNC_CLEAR  = 2'd3;

  // Result kinds
  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_FIRED  = 2'd2;
  localparam logic [1:0] KIND_CLEAR  = 2'd3;

  // Field widths fixed by the interface
  localparam int unsigned TICKS_W  = 16;
  localparam int unsigned REP_W    = 16;
  localparam int unsigned TID_W    = 32;

  // At most this many fire results per tick
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned FIRE_CNT_W  = $clog2(MAX_RESULTS + 1);

  typedef struct packed {
    logic [1:0]         func;
    logic [TICKS_W-1:0] delay_ticks;
    logic [TICKS_W-1:0] reload_ticks;
    logic [REP_W-1:0]   repeat_count;
    logic [TID_W-1:0]   target_id;
  } req_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [TID_W-1:0] timer_id;
    logic             found;
    logic             completed;
    logic             last;
  } res_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;    // latch the request and arm the walk
    logic exec;      // perform add or clear
    logic rd_issue;  // read the entry at the walk address
    logic finish;    // close the walk: commit count, send final result
  } cmd_t;

endpackage

// File: hw/rtl/ttt_ram.sv
// ----------------------------------------------------------------------------
// ttt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ttt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/ttt_ctrl.sv
// ----------------------------------------------------------------------------
// ttt_ctrl
// Controller: accepts requests, sequences add/clear and the table walk used
// by tick and remove, and drives the walk read address.
// ----------------------------------------------------------------------------
module ttt_ctrl #(
  parameter int unsigned SLOTS = 16
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          start,
  output logic                                          busy,
  input  logic [1:0]                                    func_i,
  input  logic [$clog2(SLOTS + 1)-1:0]                  count_i,
  output ttt_pkg::cmd_t                                 cmd_o,
  output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0]  rd_addr_o
);

  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_WALK = 4'b0100,
    ST_FIN  = 4'b1000
  } state_e;

  state_e          state_q, state_d;
  logic [CW-1:0]   rd_idx_q, rd_idx_d;

  // Next state and commands
  always_comb begin
    state_d  = state_q;
    rd_idx_d = rd_idx_q;
    cmd_o    = '0;
    busy     = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.accept = 1'b1;
          rd_idx_d     = '0;
          if (func_i == ttt_pkg::FUNC_TICK || func_i == ttt_pkg::FUNC_REMOVE) begin
            state_d = ST_WALK;
          end else begin
            state_d = ST_EXEC;
          end
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = ST_IDLE;
      end
      ST_WALK: begin
        // the last read issued is processed in the cycle the index hits count
        if (rd_idx_q < count_i) begin
          cmd_o.rd_issue = 1'b1;
          rd_idx_d       = rd_idx_q + CW'(1);
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd_o.finish = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign rd_addr_o = rd_idx_q[AW-1:0];

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      rd_idx_q <= '0;
    end else begin
      state_q  <= state_d;
      rd_idx_q <= rd_idx_d;
    end
  end

endmodule

// File: hw/rtl/ttt_dpath.sv
// ----------------------------------------------------------------------------
// ttt_dpath
// Datapath: timer entry RAM, occupancy count, id counter, per-entry tick and
// remove processing with in-place compaction, and the result register.
// ----------------------------------------------------------------------------
module ttt_dpath #(
  parameter int unsigned SLOTS      = 16,
  parameter int unsigned DELAY_BITS = 16,
  parameter int unsigned ID_BITS    = 32
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  ttt_pkg::req_t                                 req_i,
  input  ttt_pkg::cmd_t                                 cmd_i,
  input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0]  rd_addr_i,
  output logic [$clog2(SLOTS + 1)-1:0]                  count_o,
  output logic                                          res_valid_o,
  output ttt_pkg::res_t                                 res_o
);

  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned RW = ttt_pkg::REP_W;
  localparam int unsigned EW = ID_BITS + 2 * DELAY_BITS + RW;
  // entry layout {id, countdown, reload, repeats}
  localparam int unsigned REP_LO = 0;
  localparam int unsigned RL_LO  = RW;
  localparam int unsigned CD_LO  = RW + DELAY_BITS;
  localparam int unsigned ID_LO  = RW + 2 * DELAY_BITS;

  ttt_pkg::req_t                 req_q;
  logic [CW-1:0]                 count_q, count_d;
  logic [CW-1:0]                 wr_ptr_q, wr_ptr_d;
  logic [ID_BITS-1:0]            next_id_q, next_id_d;
  logic                          hit_q, hit_d;
  logic                          proc_q;
  logic [ttt_pkg::FIRE_CNT_W-1:0] fire_cnt_q, fire_cnt_d;
  logic                          pend_valid_q, pend_valid_d;
  logic [ID_BITS-1:0]            pend_id_q, pend_id_d;
  logic                          pend_done_q, pend_done_d;
  ttt_pkg::res_t                 res_q, res_d;
  logic                          res_valid_q, res_valid_d;

  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr;
  logic [EW-1:0]                 ram_wdata;
  logic [EW-1:0]                 ram_rdata;

  logic [ID_BITS-1:0]            e_id;
  logic [DELAY_BITS-1:0]         e_cd;
  logic [DELAY_BITS-1:0]         e_rl;
  logic [RW-1:0]                 e_rep;
  logic [DELAY_BITS-1:0]         cd_dec;
  logic [RW-1:0]                 rep_dec;
  logic [DELAY_BITS-1:0]         delay_m;
  logic [DELAY_BITS-1:0]         reload_m;
  logic [ID_BITS-1:0]            id_inc;

  ttt_ram #(
    .WIDTH (EW),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.rd_issue),
    .raddr_i (rd_addr_i),
    .rdata_o (ram_rdata)
  );

  // Entry fields and request fields at table width
  assign e_id     = ram_rdata[ID_LO +: ID_BITS];
  assign e_cd     = ram_rdata[CD_LO +: DELAY_BITS];
  assign e_rl     = ram_rdata[RL_LO +: DELAY_BITS];
  assign e_rep    = ram_rdata[REP_LO +: RW];
  assign cd_dec   = e_cd - DELAY_BITS'(1);
  assign rep_dec  = e_rep - RW'(1);
  assign delay_m  = DELAY_BITS'(req_q.delay_ticks);
  assign reload_m = DELAY_BITS'(req_q.reload_ticks);
  assign id_inc   = next_id_q + ID_BITS'(1);

  // Per-cycle processing
  always_comb begin
    logic                  fire;
    logic                  done;
    logic                  keep;
    logic [DELAY_BITS-1:0] cd_new;
    logic [RW-1:0]         rep_new;

    count_d      = count_q;
    wr_ptr_d     = wr_ptr_q;
    next_id_d    = next_id_q;
    hit_d        = hit_q;
    fire_cnt_d   = fire_cnt_q;
    pend_valid_d = pend_valid_q;
    pend_id_d    = pend_id_q;
    pend_done_d  = pend_done_q;
    res_d        = res_q;
    res_valid_d  = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = wr_ptr_q[AW-1:0];
    ram_wdata    = ram_rdata;
    fire         = 1'b0;
    done         = 1'b0;
    keep         = 1'b1;
    cd_new       = cd_dec;
    rep_new      = e_rep;

    // Arm a new walk
    if (cmd_i.accept) begin
      wr_ptr_d     = '0;
      hit_d        = 1'b0;
      fire_cnt_d   = '0;
      pend_valid_d = 1'b0;
    end

    // Add and clear
    if (cmd_i.exec) begin
      res_valid_d     = 1'b1;
      res_d           = '0;
      res_d.last      = 1'b1;
      if (req_q.func == ttt_pkg::FUNC_CLEAR) begin
        res_d.kind = ttt_pkg::KIND_CLEAR;
        count_d    = '0;
      end else begin
        res_d.kind = ttt_pkg::KIND_ADD;
        if (delay_m != '0 && count_q < CW'(SLOTS)) begin
          ram_we         = 1'b1;
          ram_waddr      = count_q[AW-1:0];
          ram_wdata      = {next_id_q, delay_m, reload_m, req_q.repeat_count};
          count_d        = count_q + CW'(1);
          res_d.timer_id = ttt_pkg::TID_W'(next_id_q);
          next_id_d      = (id_inc == '0) ? ID_BITS'(1) : id_inc;
        end
      end
    end

    // Walk: one entry read last cycle, compacted towards the write pointer
    if (proc_q) begin
      if (req_q.func == ttt_pkg::FUNC_REMOVE) begin
        if (!hit_q && ttt_pkg::TID_W'(e_id) == req_q.target_id) begin
          hit_d = 1'b1;
          keep  = 1'b0;
        end
      end else begin
        fire = (cd_dec == '0);
        if (fire) begin
          if (e_rep != '0) begin
            rep_new = rep_dec;
            if (rep_dec == '0) begin
              done = 1'b1;
            end else begin
              cd_new = e_rl;
            end
          end else begin
            done = 1'b1;
          end
        end
        keep = !done;
        // report the fire; a held one goes out now without the last flag
        if (fire && fire_cnt_q < ttt_pkg::FIRE_CNT_W'(ttt_pkg::MAX_RESULTS)) begin
          fire_cnt_d   = fire_cnt_q + ttt_pkg::FIRE_CNT_W'(1);
          pend_valid_d = 1'b1;
          pend_id_d    = e_id;
          pend_done_d  = done;
          if (pend_valid_q) begin
            res_valid_d     = 1'b1;
            res_d.kind      = ttt_pkg::KIND_FIRED;
            res_d.timer_id  = ttt_pkg::TID_W'(pend_id_q);
            res_d.found     = 1'b0;
            res_d.completed = pend_done_q;
            res_d.last      = 1'b0;
          end
        end
        ram_wdata = {e_id, cd_new, e_rl, rep_new};
      end
      if (keep) begin
        ram_we   = 1'b1;
        wr_ptr_d = wr_ptr_q + CW'(1);
      end
    end

    // End of walk
    if (cmd_i.finish) begin
      count_d = wr_ptr_q;
      if (req_q.func == ttt_pkg::FUNC_REMOVE) begin
        res_valid_d     = 1'b1;
        res_d.kind      = ttt_pkg::KIND_REMOVE;
        res_d.timer_id  = req_q.target_id;
        res_d.found     = hit_q;
        res_d.completed = 1'b0;
        res_d.last      = 1'b1;
      end else if (pend_valid_q) begin
        res_valid_d     = 1'b1;
        res_d.kind      = ttt_pkg::KIND_FIRED;
        res_d.timer_id  = ttt_pkg::TID_W'(pend_id_q);
        res_d.found     = 1'b0;
        res_d.completed = pend_done_q;
        res_d.last      = 1'b1;
        pend_valid_d    = 1'b0;
      end
    end
  end

  // Request and payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_q <= req_i;
    end
    pend_id_q   <= pend_id_d;
    pend_done_q <= pend_done_d;
    res_q       <= res_d;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      wr_ptr_q     <= '0;
      next_id_q    <= ID_BITS'(1);
      hit_q        <= 1'b0;
      proc_q       <= 1'b0;
      fire_cnt_q   <= '0;
      pend_valid_q <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      count_q      <= count_d;
      wr_ptr_q     <= wr_ptr_d;
      next_id_q    <= next_id_d;
      hit_q        <= hit_d;
      proc_q       <= cmd_i.rd_issue;
      fire_cnt_q   <= fire_cnt_d;
      pend_valid_q <= pend_valid_d;
      res_valid_q  <= res_valid_d;
    end
  end

  assign count_o     = count_q;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// File: hw/rtl/tick_timer_table.sv
// ----------------------------------------------------------------------------
// tick_timer_table
// Table of countdown timers in insertion order with add, remove, clear and
// tick requests.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Add and clear pass
// through the exec state before their result; tick and remove walk the table
// one entry per cycle through the entry RAM's single read port, then close the
// walk in the finish state. Results appear on res_o for exactly one cycle with
// res_valid_o high and cannot be held off; fire results of one tick may be
// spread over the walk, the last result of each request carries the last
// flag, and a tick with nothing firing gives no result. Id 0 in an add reply
// means the add was rejected.
module tick_timer_table #(
  parameter int unsigned SLOTS      = 16,
  parameter int unsigned DELAY_BITS = 16,
  parameter int unsigned ID_BITS    = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  ttt_pkg::req_t  req_i,
  output logic           res_valid_o,
  output ttt_pkg::res_t  res_o
);

  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  ttt_pkg::cmd_t  cmd;
  logic [AW-1:0]  rd_addr;
  logic [CW-1:0]  count;

  // Sequencer
  ttt_ctrl #(
    .SLOTS (SLOTS)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .busy      (busy),
    .func_i    (req_i.func),
    .count_i   (count),
    .cmd_o     (cmd),
    .rd_addr_o (rd_addr)
  );

  // Table and result path
  ttt_dpath #(
    .SLOTS      (SLOTS),
    .DELAY_BITS (DELAY_BITS),
    .ID_BITS    (ID_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cmd_i       (cmd),
    .rd_addr_i   (rd_addr),
    .count_o     (count),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the tick timer table against a behavioural model of its entries.
// Each request taken by the block is applied to the model at the edge that
// takes it. The replies and firings that the model predicts are queued, and
// each result strobe is compared field by field with the head of that queue.
// A short scripted section covers the corner cases. Random requests follow.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned SLOTS        = 16;
  localparam int unsigned DIRECTED     = 19;
  localparam int unsigned RANDOM_ITEMS = 270;
  localparam int unsigned LIMIT        = 200000;

  typedef struct packed {
    ttt_pkg::req_t req;
    logic          pinned;  // reply typed in below rather than taken from the model
    ttt_pkg::res_t want;
  } row_t;

  logic          clk_i  = 1'b0;
  logic          rst_ni = 1'b0;
  logic          start  = 1'b0;
  ttt_pkg::req_t req_i  = '0;
  logic          busy;
  logic          res_valid_o;
  ttt_pkg::res_t res_o;

  // Model state: live entries form a prefix of the table, oldest first
  logic [ttt_pkg::TID_W-1:0]   tmr_id     [SLOTS];
  logic [ttt_pkg::TICKS_W-1:0] tmr_count  [SLOTS];
  logic [ttt_pkg::TICKS_W-1:0] tmr_reload [SLOTS];
  logic [ttt_pkg::REP_W-1:0]   tmr_reps   [SLOTS];
  int unsigned                 tmr_live = 0;
  logic [ttt_pkg::TID_W-1:0]   id_next  = ttt_pkg::TID_W'(1);

  ttt_pkg::res_t due_q[$];
  ttt_pkg::res_t due_head;
  row_t          script [DIRECTED];
  bit            calm      = 1'b0;
  int unsigned   err_cnt   = 0;
  int unsigned   res_cnt   = 0;
  int unsigned   fire_cnt  = 0;
  int unsigned   req_cnt   = 0;
  int unsigned   cycle_cnt = 0;

  tick_timer_table u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  // Remove the entry at pos and close the gap, keeping insertion order
  function automatic void drop_timer(int unsigned pos);
    for (int unsigned j = pos; j + 1 < tmr_live; j++) begin
      tmr_id[j]     = tmr_id[j + 1];
      tmr_count[j]  = tmr_count[j + 1];
      tmr_reload[j] = tmr_reload[j + 1];
      tmr_reps[j]   = tmr_reps[j + 1];
    end
    tmr_live--;
  endfunction

  // Apply one taken request to the model and queue the results it causes
  function automatic void apply_request(ttt_pkg::req_t r, logic pinned,
                                        ttt_pkg::res_t pin_res);
    ttt_pkg::res_t batch[$];
    ttt_pkg::res_t one;
    bit            hit;
    bit            done;
    int unsigned   i;
    one = '0;
    case (r.func)
      ttt_pkg::FUNC_ADD: begin
        one.kind = ttt_pkg::KIND_ADD;
        if (r.delay_ticks != '0 && tmr_live < SLOTS) begin
          one.timer_id         = id_next;
          tmr_id[tmr_live]     = id_next;
          tmr_count[tmr_live]  = r.delay_ticks;
          tmr_reload[tmr_live] = r.reload_ticks;
          tmr_reps[tmr_live]   = r.repeat_count;
          tmr_live++;
          // ids skip zero on wrap
          id_next = id_next + 1'b1;
          if (id_next == '0) id_next = ttt_pkg::TID_W'(1);
        end
        batch = {batch, one};
      end
      ttt_pkg::FUNC_REMOVE: begin
        hit = 1'b0;
        for (i = 0; i < tmr_live && !hit; i++) begin
          if (tmr_id[i] == r.target_id) begin
            drop_timer(i);
            hit = 1'b1;
          end
        end
        one.kind     = ttt_pkg::KIND_REMOVE;
        one.timer_id = r.target_id;
        one.found    = hit;
        batch = {batch, one};
      end
      ttt_pkg::FUNC_CLEAR: begin
        tmr_live = 0;
        one.kind = ttt_pkg::KIND_CLEAR;
        batch = {batch, one};
      end
      ttt_pkg::FUNC_TICK: begin
        // every entry counts down; expired ones reload or leave the table
        i = 0;
        while (i < tmr_live) begin
          done = 1'b0;
          tmr_count[i] = tmr_count[i] - 1'b1;
          if (tmr_count[i] == '0) begin
            if (tmr_reps[i] != '0) begin
              tmr_reps[i] = tmr_reps[i] - 1'b1;
              if (tmr_reps[i] == '0) done = 1'b1;
              else tmr_count[i] = tmr_reload[i];
            end else begin
              done = 1'b1;
            end
            if (batch.size() < ttt_pkg::MAX_RESULTS) begin
              one           = '0;
              one.kind      = ttt_pkg::KIND_FIRED;
              one.timer_id  = tmr_id[i];
              one.completed = done;
              batch = {batch, one};
            end
          end
          if (done) drop_timer(i);
          else i++;
        end
      end
    endcase
    if (batch.size() > 0) begin
      one = batch.pop_back();
      one.last = 1'b1;
      batch = {batch, one};
    end
    if (pinned) due_q = {due_q, pin_res};
    else foreach (batch[k]) due_q = {due_q, batch[k]};
  endfunction

  function automatic row_t entry(logic [1:0] f, logic [15:0] d, logic [15:0] rl,
                                 logic [15:0] rp, logic [31:0] tg, logic pin,
                                 logic [1:0] k, logic [31:0] id, logic fnd);
    row_t e;
    e.req.func         = f;
    e.req.delay_ticks  = d;
    e.req.reload_ticks = rl;
    e.req.repeat_count = rp;
    e.req.target_id    = tg;
    e.pinned           = pin;
    e.want             = '0;
    e.want.kind        = k;
    e.want.timer_id    = id;
    e.want.found       = fnd;
    e.want.last        = 1'b1;
    return e;
  endfunction

  // Short timers mostly, so entries fire and complete; some full-range noise
  function automatic ttt_pkg::req_t random_request(logic [1:0] f);
    ttt_pkg::req_t r;
    r.func         = f;
    r.delay_ticks  = ttt_pkg::TICKS_W'($urandom_range(1, 6));
    r.reload_ticks = ttt_pkg::TICKS_W'($urandom_range(0, 5));
    r.repeat_count = ttt_pkg::REP_W'($urandom_range(0, 4));
    r.target_id    = $urandom;
    if ($urandom_range(0, 19) == 0) r.delay_ticks = '0;
    if (f == ttt_pkg::FUNC_REMOVE && tmr_live != 0 && $urandom_range(0, 3) != 0)
      r.target_id = tmr_id[$urandom_range(0, tmr_live - 1)];
    if ($urandom_range(0, 99) < 12) begin
      r.delay_ticks  = ttt_pkg::TICKS_W'($urandom);
      r.reload_ticks = ttt_pkg::TICKS_W'($urandom);
      r.repeat_count = ttt_pkg::REP_W'($urandom);
    end
    return r;
  endfunction

  // Offer one request and hold it until the block takes it
  task automatic push_request(input ttt_pkg::req_t r, input logic pinned,
                              input ttt_pkg::res_t pin_res);
    if (!calm && $urandom_range(0, 99) < 10) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    apply_request(r, pinned, pin_res);
    req_cnt++;
  endtask

  // Result checker: results cannot be stalled, so every strobe is consumed
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      res_cnt++;
      if (res_o.kind === ttt_pkg::KIND_FIRED) fire_cnt++;
      if (due_q.size() == 0) begin
        $error("unexpected result: kind %0d timer_id %0d", res_o.kind, res_o.timer_id);
        err_cnt++;
      end else begin
        due_head = due_q.pop_front();
        if (res_o.kind !== due_head.kind) begin
          $error("kind: expected %0d, actual %0d", due_head.kind, res_o.kind);
          err_cnt++;
        end
        if (res_o.timer_id !== due_head.timer_id) begin
          $error("timer_id: expected %0d, actual %0d", due_head.timer_id, res_o.timer_id);
          err_cnt++;
        end
        if (res_o.found !== due_head.found) begin
          $error("found: expected %0d, actual %0d", due_head.found, res_o.found);
          err_cnt++;
        end
        if (res_o.completed !== due_head.completed) begin
          $error("completed: expected %0d, actual %0d", due_head.completed,
                 res_o.completed);
          err_cnt++;
        end
        if (res_o.last !== due_head.last) begin
          $error("last: expected %0d, actual %0d", due_head.last, res_o.last);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog
  initial begin
    wait (cycle_cnt >= LIMIT);
    $display("tick_timer_table: mismatch");
    $finish;
  end

  initial begin
    int unsigned pick;
    logic [1:0]  f;
    // quiet tick on an empty table, then the corner cases of add and remove
    script[0]  = entry(ttt_pkg::FUNC_TICK, 0, 0, 0, 0, 0, ttt_pkg::KIND_FIRED, 0, 0);
    script[1]  = entry(ttt_pkg::FUNC_REMOVE, 0, 0, 0, 32'd5, 1,
                       ttt_pkg::KIND_REMOVE, 32'd5, 0);
    script[2]  = entry(ttt_pkg::FUNC_ADD, 0, 16'd7, 16'd1, 0, 1, ttt_pkg::KIND_ADD, 0, 0);
    script[3]  = entry(ttt_pkg::FUNC_ADD, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1,
                       ttt_pkg::KIND_ADD, 32'd1, 0);
    script[4]  = entry(ttt_pkg::FUNC_ADD, 16'd1, 16'd0, 16'd2, 0, 1,
                       ttt_pkg::KIND_ADD, 32'd2, 0);
    script[5]  = entry(ttt_pkg::FUNC_ADD, 16'd1, 16'd3, 16'd0, 0, 1,
                       ttt_pkg::KIND_ADD, 32'd3, 0);
    script[6]  = entry(ttt_pkg::FUNC_ADD, 16'd2, 16'd1, 16'd3, 0, 1,
                       ttt_pkg::KIND_ADD, 32'd4, 0);
    // zero reload wraps, one-shot completes, repeating entry reloads
    script[7]  = entry(ttt_pkg::FUNC_TICK, 0, 0, 0, 0, 0, ttt_pkg::KIND_FIRED, 0, 0);
    script[8]  = entry(ttt_pkg::FUNC_TICK, 0, 0, 0, 0, 0, ttt_pkg::KIND_FIRED, 0, 0);
    script[9]  = entry(ttt_pkg::FUNC_TICK, 0, 0, 0, 0, 0, ttt_pkg::KIND_FIRED, 0, 0);
    script[10] = entry(ttt_pkg::FUNC_TICK, 0, 0, 0, 0, 0, ttt_pkg::KIND_FIRED, 0, 0);
    script[11] = entry(ttt_pkg::FUNC_REMOVE, 0, 0, 0, 32'd1, 1,
                       ttt_pkg::KIND_REMOVE, 32'd1, 1);
    script[12] = entry(ttt_pkg::FUNC_REMOVE, 0, 0, 0, 32'd3, 1,
                       ttt_pkg::KIND_REMOVE, 32'd3, 0);
    script[13] = entry(ttt_pkg::FUNC_ADD, 16'd1, 16'd0, 16'd1, 0, 1,
                       ttt_pkg::KIND_ADD, 32'd5, 0);
    script[14] = entry(ttt_pkg::FUNC_TICK, 0, 0, 0, 0, 0, ttt_pkg::KIND_FIRED, 0, 0);
    script[15] = entry(ttt_pkg::FUNC_CLEAR, 0, 0, 0, 0, 1, ttt_pkg::KIND_CLEAR, 0, 0);
    script[16] = entry(ttt_pkg::FUNC_TICK, 0, 0, 0, 0, 0, ttt_pkg::KIND_FIRED, 0, 0);
    script[17] = entry(ttt_pkg::FUNC_REMOVE, 0, 0, 0, 0, 1, ttt_pkg::KIND_REMOVE, 0, 0);
    script[18] = entry(ttt_pkg::FUNC_ADD, 16'd3, 16'd2, 16'd1, 0, 1,
                       ttt_pkg::KIND_ADD, 32'd6, 0);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int unsigned k = 0; k < DIRECTED; k++)
      push_request(script[k].req, script[k].pinned, script[k].want);

    for (int unsigned k = 0; k < RANDOM_ITEMS; k++) begin
      calm = (k >= 100 && k < 160);
      // now and then empty the table, fill it past full and let it drain
      if (k % 110 == 55) begin
        push_request(random_request(ttt_pkg::FUNC_CLEAR), 1'b0, '0);
        repeat (SLOTS + 1) push_request(random_request(ttt_pkg::FUNC_ADD), 1'b0, '0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 40)      f = ttt_pkg::FUNC_TICK;
      else if (pick < 70) f = ttt_pkg::FUNC_ADD;
      else if (pick < 95) f = ttt_pkg::FUNC_REMOVE;
      else                f = ttt_pkg::FUNC_CLEAR;
      push_request(random_request(f), 1'b0, '0);
    end
    start <= 1'b0;

    // drain, then allow for a walk of a full table
    while (due_q.size() != 0) @(posedge clk_i);
    repeat (25) @(posedge clk_i);

    $display("%0d requests issued, %0d of them scripted", req_cnt, DIRECTED);
    $display("%0d results checked, %0d of them timer firings", res_cnt, fire_cnt);
    if (err_cnt == 0) begin
      $display("tick_timer_table: match");
    end else begin
      $display("tick_timer_table: mismatch");
    end
    $finish;
  end

endmodule
